>>> design/ctc_pkg.sv
// Package for the command token classifier.
// Holds result record type, kind and keyword codes, keyword text and hex helpers.
// No dependencies.
package ctc_pkg;

    localparam logic [7:0] MAX_TOKENS     = 8'd3;
    localparam logic [7:0] MAX_HEX_DIGITS = 8'd4;
    localparam logic [7:0] DELIM_RESET    = 8'd32;
    localparam int         KW_COUNT       = 4;

    typedef enum logic [1:0] {
        KIND_KEYWORD = 2'd0,
        KIND_NUMBER  = 2'd1,
        KIND_STRING  = 2'd2,
        KIND_NONE    = 2'd3
    } kind_t;

    typedef enum logic [1:0] {
        KW_CALLIB = 2'd0,
        KW_GOTO   = 2'd1,
        KW_ID     = 2'd2,
        KW_BUTTON = 2'd3
    } kw_t;

    typedef struct packed {
        kind_t       kind;
        kw_t         keyword;
        logic [15:0] number;
        logic [7:0]  index;
        logic [7:0]  start;
        logic        eom;
        logic [7:0]  count;
    } res_t;

    function automatic logic [7:0] kw_len(input kw_t k);
        logic [7:0] len;
        unique case (k)
            KW_CALLIB: len = 8'd6;
            KW_GOTO:   len = 8'd4;
            KW_ID:     len = 8'd2;
            KW_BUTTON: len = 8'd6;
            default:   len = 8'd0;
        endcase
        return len;
    endfunction

    // Character at position p of keyword k; zero past the end.
    function automatic logic [7:0] kw_char(input kw_t k, input logic [2:0] p);
        logic [47:0] text;
        logic [7:0]  ch;
        unique case (k)
            KW_CALLIB: text = {"b", "i", "l", "l", "a", "c"};
            KW_GOTO:   text = {8'd0, 8'd0, "o", "t", "o", "g"};
            KW_ID:     text = {32'd0, "d", "i"};
            KW_BUTTON: text = {"n", "o", "t", "t", "u", "b"};
            default:   text = '0;
        endcase
        unique case (p)
            3'd0:    ch = text[7:0];
            3'd1:    ch = text[15:8];
            3'd2:    ch = text[23:16];
            3'd3:    ch = text[31:24];
            3'd4:    ch = text[39:32];
            3'd5:    ch = text[47:40];
            default: ch = 8'd0;
        endcase
        return ch;
    endfunction

    // {is_digit, value}
    function automatic logic [4:0] hex_digit(input logic [7:0] c);
        logic [4:0] r;
        r = 5'd0;
        if (c >= "0" && c <= "9") begin
            r = {1'b1, 4'(c - 8'h30)};
        end else if (c >= "A" && c <= "F") begin
            r = {1'b1, 4'(c - 8'h37)};
        end else if (c >= "a" && c <= "f") begin
            r = {1'b1, 4'(c - 8'h57)};
        end
        return r;
    endfunction

endpackage

>>> design/command_token_classifier_top.sv
// Command token classifier: splits a zero-terminated byte stream into tokens
// and classifies each as keyword, hex number or string.
// Depends on ctc_pkg.
// Records leave from a register. Throughput: one byte per cycle unless the skid
// entry is full (s_ready low); the per-byte keyword, hex and tokenizer logic
// sits between the state registers and a two-entry output register with skid.
// Reset (aresetn low, synchronous): message state cleared, delimiter back to 32,
// output and skid registers emptied.
module command_token_classifier_top
    import ctc_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [7:0]  s_char_code,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [7:0]  cfg_data,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [1:0]  m_token_kind,
    output logic [1:0]  m_keyword_code,
    output logic [15:0] m_number_value,
    output logic [7:0]  m_token_index,
    output logic [7:0]  m_token_start,
    output logic        m_end_of_message,
    output logic [7:0]  m_token_count
);

    logic [7:0]  delim_reg;
    logic        in_token_reg,  in_token_next;
    logic [7:0]  tokens_reg,    tokens_next;
    logic [7:0]  offset_reg,    offset_next;
    logic [7:0]  start_reg,     start_next;
    logic [7:0]  cit_reg,       cit_next;
    logic [3:0]  match_reg,     match_next;
    logic [15:0] acc_reg,       acc_next;
    logic        hex_ok_reg,    hex_ok_next;

    res_t        out_reg,  out_next;
    logic        out_valid_reg, out_valid_next;
    res_t        skid_reg, skid_next;
    logic        skid_valid_reg, skid_valid_next;

    logic        accept;
    logic        push;
    res_t        res;
    res_t        tok_rec;

    // absorb inputs: fresh values when a token starts on this byte
    logic [7:0]  ab_p;
    logic [3:0]  ab_match;
    logic [15:0] ab_acc;
    logic        ab_hex_ok;
    logic        ab_en;
    logic        starting;
    logic [4:0]  hd;

    assign s_ready   = !skid_valid_reg;
    assign cfg_ready = 1'b1;
    assign accept    = s_valid && s_ready;

    // Record for the currently open token, from registered state.
    always_comb begin
        tok_rec         = '0;
        tok_rec.kind    = KIND_STRING;
        tok_rec.keyword = KW_CALLIB;
        for (int k = KW_COUNT - 1; k >= 0; k--) begin
            if (match_reg[k] && cit_reg == kw_len(kw_t'(k))) begin
                tok_rec.kind    = KIND_KEYWORD;
                tok_rec.keyword = kw_t'(k);
            end
        end
        if (tok_rec.kind == KIND_STRING && hex_ok_reg && cit_reg >= 8'd3) begin
            tok_rec.kind   = KIND_NUMBER;
            tok_rec.number = acc_reg;
        end
        tok_rec.index = tokens_reg - 8'd1;
        tok_rec.start = start_reg;
    end

    assign starting  = !in_token_reg && tokens_reg < MAX_TOKENS;
    assign ab_p      = starting ? 8'd0   : cit_reg;
    assign ab_match  = starting ? 4'hF   : match_reg;
    assign ab_acc    = starting ? 16'd0  : acc_reg;
    assign ab_hex_ok = starting ? 1'b1   : hex_ok_reg;
    assign hd        = hex_digit(s_char_code);

    always_comb begin
        in_token_next = in_token_reg;
        tokens_next   = tokens_reg;
        offset_next   = offset_reg;
        start_next    = start_reg;
        cit_next      = cit_reg;
        match_next    = match_reg;
        acc_next      = acc_reg;
        hex_ok_next   = hex_ok_reg;
        res           = tok_rec;
        push          = 1'b0;
        ab_en         = 1'b0;

        if (accept) begin
            if (offset_reg != 8'hFF) begin
                offset_next = offset_reg + 8'd1;
            end
            priority if (s_char_code == 8'd0) begin
                push = 1'b1;
                if (!in_token_reg) begin
                    res      = '0;
                    res.kind = KIND_NONE;
                end
                res.eom       = 1'b1;
                res.count     = tokens_reg;
                in_token_next = 1'b0;
                tokens_next   = 8'd0;
                offset_next   = 8'd0;
                start_next    = 8'd0;
                cit_next      = 8'd0;
                match_next    = 4'hF;
                acc_next      = 16'd0;
                hex_ok_next   = 1'b1;
            end else if (s_char_code == delim_reg) begin
                push          = in_token_reg;
                in_token_next = 1'b0;
            end else if (in_token_reg) begin
                ab_en = 1'b1;
            end else if (starting) begin
                ab_en         = 1'b1;
                in_token_next = 1'b1;
                tokens_next   = tokens_reg + 8'd1;
                start_next    = offset_reg;
            end else begin
                // token beyond the limit: only the offset advances
            end
        end

        if (ab_en) begin
            for (int k = 0; k < KW_COUNT; k++) begin
                match_next[k] = ab_match[k] && ab_p < kw_len(kw_t'(k))
                                && s_char_code == kw_char(kw_t'(k), ab_p[2:0]);
            end
            acc_next    = ab_acc;
            hex_ok_next = ab_hex_ok;
            priority if (ab_p == 8'd0) begin
                if (s_char_code != "0") hex_ok_next = 1'b0;
            end else if (ab_p == 8'd1) begin
                if (s_char_code != "x") hex_ok_next = 1'b0;
            end else if (!hd[4] || (ab_p - 8'd2) >= MAX_HEX_DIGITS) begin
                hex_ok_next = 1'b0;
            end else begin
                acc_next = {ab_acc[11:0], hd[3:0]};
            end
            cit_next = (ab_p != 8'hFF) ? ab_p + 8'd1 : ab_p;
        end
    end

    // Output register plus skid entry; order is kept, skid drains first.
    always_comb begin
        out_next        = out_reg;
        out_valid_next  = out_valid_reg;
        skid_next       = skid_reg;
        skid_valid_next = skid_valid_reg;
        if (out_valid_reg && m_ready) begin
            if (skid_valid_reg) begin
                out_next        = skid_reg;
                skid_valid_next = 1'b0;
            end else begin
                out_valid_next = 1'b0;
            end
        end
        if (push) begin
            if (!out_valid_next) begin
                out_next       = res;
                out_valid_next = 1'b1;
            end else begin
                skid_next       = res;
                skid_valid_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            delim_reg      <= DELIM_RESET;
            in_token_reg   <= 1'b0;
            tokens_reg     <= 8'd0;
            offset_reg     <= 8'd0;
            start_reg      <= 8'd0;
            cit_reg        <= 8'd0;
            match_reg      <= 4'hF;
            acc_reg        <= 16'd0;
            hex_ok_reg     <= 1'b1;
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end else begin
            if (cfg_valid && cfg_ready) begin
                delim_reg <= cfg_data;
            end
            in_token_reg   <= in_token_next;
            tokens_reg     <= tokens_next;
            offset_reg     <= offset_next;
            start_reg      <= start_next;
            cit_reg        <= cit_next;
            match_reg      <= match_next;
            acc_reg        <= acc_next;
            hex_ok_reg     <= hex_ok_next;
            out_valid_reg  <= out_valid_next;
            skid_valid_reg <= skid_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        out_reg  <= out_next;
        skid_reg <= skid_next;
    end

    assign m_valid          = out_valid_reg;
    assign m_token_kind     = out_reg.kind;
    assign m_keyword_code   = out_reg.keyword;
    assign m_number_value   = out_reg.number;
    assign m_token_index    = out_reg.index;
    assign m_token_start    = out_reg.start;
    assign m_end_of_message = out_reg.eom;
    assign m_token_count    = out_reg.count;

`ifndef SYNTHESIS
    a_skid_behind_out: assert property (@(posedge aclk) disable iff (!aresetn)
        skid_valid_reg |-> out_valid_reg)
        else $error("skid entry held while output register empty");

    a_token_limit: assert property (@(posedge aclk) disable iff (!aresetn)
        tokens_reg <= MAX_TOKENS)
        else $error("token count past limit");

    a_count_limit: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_end_of_message) |-> m_token_count <= MAX_TOKENS)
        else $error("end record count past limit");

    a_end_clears: assert property (@(posedge aclk) disable iff (!aresetn)
        (accept && s_char_code == 8'd0) |=> (tokens_reg == 8'd0 && !in_token_reg
                                             && offset_reg == 8'd0))
        else $error("message state not cleared after end byte");
`endif

endmodule

>>> sim/command_token_classifier_top_test.sv
// Self-checking bench for command_token_classifier_top: byte stream in, token records out.
// A scoreboard tracks the tokenizer state and predicts each record. Random stalls are used on both sides.
// Depends on ctc_pkg and the design sources.
module command_token_classifier_top_test
    import ctc_pkg::*;
();

    localparam logic [7:0] END_BYTE = 8'h00;

    class token_scoreboard;
        logic [7:0]  delim;
        bit          in_tok;
        logic [7:0]  tok_seen;
        logic [7:0]  offset;
        logic [7:0]  cur_start;
        logic [7:0]  tok_len;
        logic [3:0]  kw_live;
        logic [15:0] hex_acc;
        bit          hex_ok;
        res_t        pending[$];
        int          errors;
        int          records;
        int          kind_hits[4];

        function new();
            delim = DELIM_RESET;
            errors = 0;
            records = 0;
            kind_hits = '{0, 0, 0, 0};
            clear_message();
        endfunction

        function void clear_message();
            in_tok = 1'b0;
            tok_seen = '0;
            offset = '0;
            cur_start = '0;
            tok_len = '0;
            kw_live = '1;
            hex_acc = '0;
            hex_ok = 1'b1;
        endfunction

        function string spelling(kw_t k);
            case (k)
                KW_CALLIB: return "callib";
                KW_GOTO:   return "goto";
                KW_ID:     return "id";
                KW_BUTTON: return "button";
                default:   return "";
            endcase
        endfunction

        function int digit_value(logic [7:0] c);
            if (c >= "0" && c <= "9") return c - "0";
            if (c >= "A" && c <= "F") return c - "A" + 10;
            if (c >= "a" && c <= "f") return c - "a" + 10;
            return -1;
        endfunction

        function void absorb(logic [7:0] c);
            int    p;
            int    d;
            string w;
            p = tok_len;
            for (int k = 0; k < KW_COUNT; k++) begin
                w = spelling(kw_t'(k));
                if (p >= w.len() || w[p] != c) kw_live[k] = 1'b0;
            end
            if (p == 0) begin
                if (c != "0") hex_ok = 1'b0;
            end else if (p == 1) begin
                if (c != "x") hex_ok = 1'b0;
            end else begin
                d = digit_value(c);
                if (d < 0 || p - 2 >= int'(MAX_HEX_DIGITS)) hex_ok = 1'b0;
                else hex_acc = {hex_acc[11:0], d[3:0]};
            end
            if (tok_len != 8'hFF) tok_len++;
        endfunction

        function res_t token_record();
            res_t  r;
            string w;
            r = '0;
            r.kind = KIND_STRING;
            for (int k = 0; k < KW_COUNT; k++) begin
                w = spelling(kw_t'(k));
                if (kw_live[k] && tok_len == w.len()) begin
                    r.kind = KIND_KEYWORD;
                    r.keyword = kw_t'(k);
                    break;
                end
            end
            // a keyword can never also look like 0x..., so it takes priority
            if (r.kind == KIND_STRING && hex_ok && tok_len >= 3) begin
                r.kind = KIND_NUMBER;
                r.number = hex_acc;
            end
            r.index = tok_seen - 8'd1;
            r.start = cur_start;
            return r;
        endfunction

        // called for every byte transfer on the input channel
        function void note_byte(logic [7:0] c);
            res_t r;
            if (c == END_BYTE) begin
                if (in_tok) begin
                    r = token_record();
                end else begin
                    r = '0;
                    r.kind = KIND_NONE;
                end
                r.eom = 1'b1;
                r.count = tok_seen;
                pending.push_back(r);
                clear_message();
                return;
            end
            if (c == delim) begin
                if (in_tok) begin
                    pending.push_back(token_record());
                    in_tok = 1'b0;
                end
            end else if (in_tok) begin
                absorb(c);
            end else if (tok_seen < MAX_TOKENS) begin
                in_tok = 1'b1;
                tok_seen++;
                cur_start = offset;
                tok_len = '0;
                kw_live = '1;
                hex_acc = '0;
                hex_ok = 1'b1;
                absorb(c);
            end
            if (offset != 8'hFF) offset++;
        endfunction

        function void check_field(string name, logic [15:0] want, logic [15:0] seen);
            if (seen !== want) begin
                $error("%s: expected %0d, got %0d", name, want, seen);
                errors++;
            end
        endfunction

        // called for every record transfer on the result channel
        function void check_record(res_t got);
            res_t want;
            if (pending.size() == 0) begin
                $error("record with nothing pending: kind %0d index %0d", got.kind, got.index);
                errors++;
                return;
            end
            want = pending.pop_front();
            check_field("token_kind", want.kind, got.kind);
            check_field("keyword_code", want.keyword, got.keyword);
            check_field("number_value", want.number, got.number);
            check_field("token_index", want.index, got.index);
            check_field("token_start", want.start, got.start);
            check_field("end_of_message", want.eom, got.eom);
            check_field("token_count", want.count, got.count);
            kind_hits[want.kind]++;
            records++;
        endfunction
    endclass

    logic        aclk;
    logic        aresetn = 1'b0;
    logic        s_valid = 1'b0;
    logic        s_ready;
    logic [7:0]  s_char_code = '0;
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic [7:0]  cfg_data = '0;
    logic        m_valid;
    logic        m_ready = 1'b0;
    logic [1:0]  m_token_kind;
    logic [1:0]  m_keyword_code;
    logic [15:0] m_number_value;
    logic [7:0]  m_token_index;
    logic [7:0]  m_token_start;
    logic        m_end_of_message;
    logic [7:0]  m_token_count;

    token_scoreboard sb;
    logic [7:0]      msg_bytes[$];
    int              gap_pct = 0;
    int              sink_hold = 0;
    int              bytes_sent = 0;
    int              delim_writes = 0;

    command_token_classifier_top uut (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .s_valid          (s_valid),
        .s_ready          (s_ready),
        .s_char_code      (s_char_code),
        .cfg_valid        (cfg_valid),
        .cfg_ready        (cfg_ready),
        .cfg_data         (cfg_data),
        .m_valid          (m_valid),
        .m_ready          (m_ready),
        .m_token_kind     (m_token_kind),
        .m_keyword_code   (m_keyword_code),
        .m_number_value   (m_number_value),
        .m_token_index    (m_token_index),
        .m_token_start    (m_token_start),
        .m_end_of_message (m_end_of_message),
        .m_token_count    (m_token_count)
    );

    initial begin
        aclk = 1'b0;
        forever #2 aclk = ~aclk;
    end

    initial begin
        #2_000_000;
        $display("tb: failure");
        $finish;
    end

    // result side back-pressure: m_ready dropped in random bursts while gap_pct is nonzero
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_ready <= 1'b0;
            sink_hold = 0;
        end else if (sink_hold > 0) begin
            sink_hold--;
            m_ready <= 1'b0;
        end else if (gap_pct > 0 && $urandom_range(0, 99) < gap_pct) begin
            sink_hold = $urandom_range(0, 14);
            m_ready <= 1'b0;
        end else begin
            m_ready <= 1'b1;
        end
    end

    always @(posedge aclk) begin
        if (aresetn && s_valid && s_ready) begin
            sb.note_byte(s_char_code);
            bytes_sent++;
        end
        if (aresetn && m_valid && m_ready)
            sb.check_record(res_t'({m_token_kind, m_keyword_code, m_number_value,
                                    m_token_index, m_token_start, m_end_of_message,
                                    m_token_count}));
    end

    task automatic send_byte(input logic [7:0] c);
        if (gap_pct > 0 && $urandom_range(0, 99) < gap_pct) begin
            s_valid <= 1'b0;
            repeat ($urandom_range(1, 15)) @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_char_code <= c;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
    endtask

    task automatic send_queued();
        for (int i = 0; i < msg_bytes.size(); i++) send_byte(msg_bytes[i]);
        msg_bytes.delete();
    endtask

    // hold off the sender until every pending record has been seen
    task automatic wait_drain();
        s_valid <= 1'b0;
        @(posedge aclk);
        while (sb.pending.size() != 0) @(posedge aclk);
        repeat (4) @(posedge aclk);
    endtask

    task automatic write_delim(input logic [7:0] d);
        wait_drain();
        cfg_valid <= 1'b1;
        cfg_data <= d;
        @(posedge aclk);
        while (!cfg_ready) @(posedge aclk);
        cfg_valid <= 1'b0;
        sb.delim = d;
        delim_writes++;
    endtask

    function automatic void add_text(string s);
        for (int i = 0; i < s.len(); i++) msg_bytes.push_back(s[i]);
    endfunction

    function automatic logic [7:0] other_byte();
        logic [7:0] b;
        do b = 8'($urandom_range(1, 255)); while (b == sb.delim);
        return b;
    endfunction

    function automatic void add_delims(int n);
        repeat (n) msg_bytes.push_back(sb.delim);
    endfunction

    // keyword, sometimes cut short, lengthened or with one byte changed
    function automatic void add_keyword();
        string w;
        int    pick;
        w = sb.spelling(kw_t'($urandom_range(0, KW_COUNT - 1)));
        pick = $urandom_range(0, 9);
        if (pick == 0) begin
            add_text(w.substr(0, w.len() - 2));
        end else begin
            add_text(w);
            if (pick == 1)
                msg_bytes.push_back("s");
            else if (pick == 2)
                msg_bytes[msg_bytes.size() - 1 - $urandom_range(0, w.len() - 1)] =
                    8'($urandom_range(1, 255));
        end
    endfunction

    function automatic void add_hex();
        string digits;
        int    n;
        digits = "0123456789abcdefABCDEF";
        msg_bytes.push_back("0");
        msg_bytes.push_back(($urandom_range(0, 15) == 0) ? "X" : "x");
        n = ($urandom_range(0, 7) == 0) ? $urandom_range(0, 6)
                                         : $urandom_range(1, MAX_HEX_DIGITS);
        repeat (n) msg_bytes.push_back(digits[$urandom_range(0, digits.len() - 1)]);
        if ($urandom_range(0, 9) == 0) msg_bytes.push_back("g");
    endfunction

    task automatic send_message();
        int ntok;
        int r;
        add_delims($urandom_range(0, 2));
        ntok = $urandom_range(0, 5);
        for (int t = 0; t < ntok; t++) begin
            r = $urandom_range(0, 99);
            if (r < 40) add_keyword();
            else if (r < 75) add_hex();
            else repeat ($urandom_range(1, 8)) msg_bytes.push_back(other_byte());
            if (t < ntok - 1 || $urandom_range(0, 1) == 1) add_delims($urandom_range(1, 3));
        end
        // raw noise; a zero in here cuts the message short
        if ($urandom_range(0, 9) == 0)
            repeat ($urandom_range(1, 6)) msg_bytes.push_back(8'($urandom_range(0, 255)));
        msg_bytes.push_back(END_BYTE);
        send_queued();
    endtask

    task automatic run_phase(input logic [7:0] d, input int pct, input int quota);
        int first;
        write_delim(d);
        gap_pct = pct;
        first = bytes_sent;
        while (bytes_sent - first < quota) send_message();
    endtask

    initial begin
        sb = new();
        repeat (6) @(posedge aclk);
        aresetn <= 1'b1;

        // delimiter is still the reset value (space) here
        add_text("goto button");
        msg_bytes.push_back(END_BYTE);
        add_text("callib 0xF id ");
        msg_bytes.push_back(8'hFF);
        msg_bytes.push_back(END_BYTE);
        send_queued();

        run_phase(8'd1, 10, 130);
        run_phase(8'hFF, 30, 130);
        run_phase(8'($urandom_range(1, 255)), 0, 130);

        // long token saturates its length, long message saturates the start offset
        repeat (300) msg_bytes.push_back(other_byte());
        add_delims(1);
        add_text("goto");
        msg_bytes.push_back(END_BYTE);
        add_delims(258);
        add_text("0x1");
        msg_bytes.push_back(END_BYTE);
        send_queued();

        run_phase("x", 20, 130);
        run_phase(8'($urandom_range(1, 255)), 10, 130);
        run_phase(DELIM_RESET, 0, 130);
        wait_drain();

        $display("tb: %0d bytes, %0d records (%0d keyword, %0d number, %0d string, %0d empty)",
                 bytes_sent, sb.records, sb.kind_hits[KIND_KEYWORD], sb.kind_hits[KIND_NUMBER],
                 sb.kind_hits[KIND_STRING], sb.kind_hits[KIND_NONE]);
        $display("tb: %0d delimiter settings, stalls on both channels", delim_writes);
        if (sb.errors == 0 && sb.pending.size() == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end

endmodule

>>> files.f
design/ctc_pkg.sv
design/command_token_classifier_top.sv
sim/command_token_classifier_top_test.sv
